// ===== hdl/mmdp_pkg.sv =====
// shared types and constants of the mp4 movie duration parser
package mmdp_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [31:0] TAG_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] TAG_MVHD = 32'h6D76_6864;

  localparam logic [63:0] HDR_LEN = 64'd8;
  localparam logic [63:0] LARGE_HDR_LEN = 64'd16;
  localparam logic [4:0] HDR_LAST_SHORT = 5'd7;
  localparam logic [4:0] HDR_LAST_LARGE = 5'd15;

  localparam logic [4:0] V0_TS_AT = 5'd12;
  localparam logic [4:0] V0_DU_AT = 5'd16;
  localparam logic [4:0] V0_DU_END = 5'd20;
  localparam logic [4:0] V1_TS_AT = 5'd20;
  localparam logic [4:0] V1_DU_AT = 5'd24;
  localparam logic [5:0] V1_DU_END = 6'd32;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_MOOV = 2'd1,
    ST_NO_MVHD = 2'd2,
    ST_TS_ZERO = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_SEEK_MOOV,
    PH_SEEK_MVHD,
    PH_BODY,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  version;
    logic [31:0] timescale;
    logic [63:0] duration;
  } job_t;

endpackage

// ===== hdl/mmdp_front.sv =====
// byte parser: walks box headers, finds moov and mvhd, reads the mvhd fields
module mmdp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output mmdp_pkg::job_t job_o
);
  import mmdp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [31:0] tag_q, tag_d;
  logic [63:0] skip_q, skip_d;
  logic [7:0]  ver_q, ver_d;
  logic [31:0] ts_q, ts_d;
  logic [63:0] dur_q, dur_d;

  logic        accept;
  logic        hdr_end;
  logic        ver1;
  logic [63:0] hlen;
  logic [31:0] target;
  logic [4:0]  ts_at;
  logic [4:0]  du_at;
  logic [5:0]  du_end;

  assign in_stall_o = fifo_full_i;
  assign accept = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK_MOOV;
      cnt_q   <= '0;
      len_q   <= '0;
      tag_q   <= '0;
      skip_q  <= '0;
      ver_q   <= '0;
      ts_q    <= '0;
      dur_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      tag_q   <= tag_d;
      skip_q  <= skip_d;
      ver_q   <= ver_d;
      ts_q    <= ts_d;
      dur_q   <= dur_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    tag_d   = tag_q;
    skip_d  = skip_q;
    ver_d   = ver_q;
    ts_d    = ts_q;
    dur_d   = dur_q;
    push_o  = 1'b0;
    job_o   = '{status: ST_FOUND, version: '0, timescale: '0, duration: '0};
    hdr_end = 1'b0;
    hlen    = HDR_LEN;
    target  = (phase_q == PH_SEEK_MOOV) ? TAG_MOOV : TAG_MVHD;
    ver1    = (ver_q == 8'd1);
    ts_at   = ver1 ? V1_TS_AT : V0_TS_AT;
    du_at   = ver1 ? V1_DU_AT : V0_DU_AT;
    du_end  = ver1 ? V1_DU_END : {1'b0, V0_DU_END};

    if (accept) begin
      unique case (phase_q)
        PH_SEEK_MOOV, PH_SEEK_MVHD: begin
          if (skip_q != '0) begin
            skip_d = skip_q - 64'd1;
          end else begin
            if (cnt_q == 5'd0 || cnt_q == 5'd8) begin
              len_d = {56'd0, data_byte_i};
            end else if (cnt_q < 5'd4 || (cnt_q > 5'd8 && cnt_q < 5'd16)) begin
              len_d = {len_q[55:0], data_byte_i};
            end else begin
              tag_d = {tag_q[23:0], data_byte_i};
            end
            cnt_d = cnt_q + 5'd1;
            if (cnt_q == HDR_LAST_SHORT && len_d != 64'd1) begin
              hdr_end = 1'b1;
            end else if (cnt_q == HDR_LAST_LARGE) begin
              hdr_end = 1'b1;
              hlen    = LARGE_HDR_LEN;
            end
            if (hdr_end) begin
              cnt_d = '0;
              if (tag_d == target) begin
                if (phase_q == PH_SEEK_MOOV) begin
                  phase_d = PH_SEEK_MVHD;
                end else begin
                  phase_d = PH_BODY;
                  ver_d   = '0;
                  ts_d    = '0;
                  dur_d   = '0;
                end
              end else if (len_d == '0 || len_d < hlen) begin
                push_o       = 1'b1;
                job_o.status = (phase_q == PH_SEEK_MOOV) ? ST_NO_MOOV : ST_NO_MVHD;
                phase_d      = PH_DONE;
              end else begin
                skip_d = len_d - hlen;
              end
            end
          end
        end
        PH_BODY: begin
          if (cnt_q == 5'd0) begin
            ver_d = data_byte_i;
          end else if (cnt_q >= ts_at && cnt_q < du_at) begin
            ts_d = {ts_q[23:0], data_byte_i};
          end else if (cnt_q >= du_at && {1'b0, cnt_q} < du_end) begin
            dur_d = {dur_q[55:0], data_byte_i};
          end
          cnt_d = cnt_q + 5'd1;
          if (cnt_q != 5'd0 && ({1'b0, cnt_q} + 6'd1) == du_end) begin
            push_o          = 1'b1;
            job_o.status    = (ts_d == '0) ? ST_TS_ZERO : ST_FOUND;
            job_o.version   = ver_q;
            job_o.timescale = ts_d;
            job_o.duration  = dur_d;
            phase_d         = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (last_byte_i) begin
        if (!push_o && phase_q != PH_DONE) begin
          push_o       = 1'b1;
          job_o.status = (phase_d == PH_SEEK_MOOV) ? ST_NO_MOOV : ST_NO_MVHD;
        end
        phase_d = PH_SEEK_MOOV;
        cnt_d   = '0;
        len_d   = '0;
        tag_d   = '0;
        skip_d  = '0;
        ver_d   = '0;
        ts_d    = '0;
        dur_d   = '0;
      end
    end
  end

endmodule

// ===== hdl/mmdp_fifo.sv =====
// short result queue between the parser and the divider
module mmdp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mmdp_pkg::job_t job_i,
  input  logic           pop_i,
  output mmdp_pkg::job_t job_o,
  output logic           full_o,
  output logic           valid_o
);
  import mmdp_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  job_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== hdl/mmdp_divider.sv =====
// bit-serial divider of duration by timescale and the result register
module mmdp_divider #(
  parameter int unsigned FRACTION_BITS = mmdp_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  mmdp_pkg::job_t       job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mmdp_pkg::status_e    status_o,
  output logic [7:0]           header_version_o,
  output logic [31:0]          ticks_per_second_o,
  output logic [63:0]          duration_ticks_o,
  output logic [63:0]          whole_seconds_o,
  output logic [15:0]          second_fraction_o
);
  import mmdp_pkg::*;

  localparam int unsigned QuotW = 64 + FRACTION_BITS;
  localparam int unsigned CntW = $clog2(QuotW + 1);

  back_e            st_q, st_d;
  status_e          stat_q, stat_d;
  logic [7:0]       ver_q, ver_d;
  logic [31:0]      ts_q, ts_d;
  logic [63:0]      dur_q, dur_d;
  logic [31:0]      rem_q, rem_d;
  logic [QuotW-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [32:0]      trial;
  logic             qbit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BK_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    ver_q  <= ver_d;
    ts_q   <= ts_d;
    dur_q  <= dur_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    stat_d = stat_q;
    ver_d  = ver_q;
    ts_d   = ts_q;
    dur_d  = dur_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    pop_o  = 1'b0;
    trial  = {rem_q, quo_q[QuotW-1]};
    qbit   = (trial >= {1'b0, ts_q});

    unique case (st_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          pop_o  = 1'b1;
          stat_d = job_i.status;
          ver_d  = job_i.version;
          ts_d   = job_i.timescale;
          dur_d  = job_i.duration;
          rem_d  = '0;
          cnt_d  = CntW'(QuotW);
          if (job_i.status == ST_FOUND) begin
            quo_d = QuotW'(job_i.duration) << FRACTION_BITS;
            st_d  = BK_DIV;
          end else begin
            quo_d = '0;
            st_d  = BK_HOLD;
          end
        end
      end
      BK_DIV: begin
        if (qbit) begin
          rem_d = 32'(trial - {1'b0, ts_q});
        end else begin
          rem_d = trial[31:0];
        end
        quo_d = {quo_q[QuotW-2:0], qbit};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          st_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (!out_stall_i) begin
          st_d = BK_IDLE;
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  assign out_valid_o        = (st_q == BK_HOLD);
  assign status_o           = stat_q;
  assign header_version_o   = ver_q;
  assign ticks_per_second_o = ts_q;
  assign duration_ticks_o   = dur_q;
  assign whole_seconds_o    = quo_q[QuotW-1 -: 64];

  generate
    if (FRACTION_BITS >= 16) begin : g_frac_wide
      assign second_fraction_o = quo_q[15:0];
    end else if (FRACTION_BITS > 0) begin : g_frac_narrow
      assign second_fraction_o = 16'(quo_q[FRACTION_BITS-1:0]);
    end else begin : g_frac_none
      assign second_fraction_o = '0;
    end
  endgenerate

endmodule

// ===== hdl/mp4_movie_duration_parser.sv =====
// top level of the mp4 movie duration parser
//
//   channel  direction  handshake             beat
//   input    in         in_valid_i/in_stall_o   data_byte_i, last_byte_i
//   output   out        out_valid_o/out_stall_i status_o .. second_fraction_o
//
// one file byte a cycle while the queue is not full; the parser never stalls on its own
// with queue and divider idle, a result is queued, taken by the divider, divided bit by bit
//   in BK_DIV if found, and shown with out_valid_o in BK_HOLD; other results skip BK_DIV
// two results queued ahead of the divider stall the byte input
// rst_ni clears the parser to the moov search and empties queue and divider
module mp4_movie_duration_parser #(
  parameter int unsigned FRACTION_BITS = mmdp_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  header_version_o,
  output logic [31:0] ticks_per_second_o,
  output logic [63:0] duration_ticks_o,
  output logic [63:0] whole_seconds_o,
  output logic [15:0] second_fraction_o
);
  import mmdp_pkg::*;

  logic    push;
  job_t    push_job;
  logic    fifo_full;
  logic    fifo_valid;
  job_t    head_job;
  logic    pop;
  status_e status;

  mmdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  mmdp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (fifo_full),
    .valid_o (fifo_valid)
  );

  mmdp_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (fifo_valid),
    .job_i              (head_job),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status),
    .header_version_o   (header_version_o),
    .ticks_per_second_o (ticks_per_second_o),
    .duration_ticks_o   (duration_ticks_o),
    .whole_seconds_o    (whole_seconds_o),
    .second_fraction_o  (second_fraction_o)
  );

  assign status_o = status;

endmodule

// ===== tb/tb_mp4_movie_duration_parser.sv =====
// testbench of the mp4 movie duration parser: random and directed files, scoreboard checking
`timescale 1ns / 100ps

module tb_mp4_movie_duration_parser;
  import mmdp_pkg::*;

  localparam int unsigned FRAC_BITS = FRACTION_BITS_DEF;
  localparam int IDLE_LIMIT = 6000;
  localparam int LONG_HOLD = 1500;
  localparam int LONG_HOLD_AT = 20;
  localparam int DRAIN_AT_FILE = 28;
  localparam int BYTE_TARGET = 1750;
  localparam int FILE_TARGET = 30;
  localparam int DIRECTED_FILES = 15;

  typedef struct packed {
    status_e     status;
    logic [7:0]  version;
    logic [31:0] scale;
    logic [63:0] ticks;
    logic [63:0] whole;
    logic [15:0] frac;
  } duration_rec_t;

  class duration_scoreboard;
    phase_e        stage;
    logic [5:0]    pos;
    logic [63:0]   size_acc;
    logic [31:0]   tag_acc;
    logic [63:0]   skip_cnt;
    logic [7:0]    ver;
    logic [31:0]   scale;
    logic [63:0]   ticks;
    bit            done;
    duration_rec_t expected_durations[$];
    int            errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      stage = PH_SEEK_MOOV;
      pos = '0;
      size_acc = '0;
      tag_acc = '0;
      skip_cnt = '0;
      ver = '0;
      scale = '0;
      ticks = '0;
      done = 1'b0;
    endfunction

    function void post_result(status_e st, bit with_vals);
      duration_rec_t r;
      logic [63:0] rem;
      logic [63:0] quot;
      r.status = st;
      r.version = with_vals ? ver : 8'd0;
      r.scale = with_vals ? scale : 32'd0;
      r.ticks = with_vals ? ticks : 64'd0;
      r.whole = '0;
      r.frac = '0;
      if (st == ST_FOUND && scale != 0) begin
        r.whole = ticks / {32'd0, scale};
        rem = ticks % {32'd0, scale};
        quot = (rem << FRAC_BITS) / {32'd0, scale};
        r.frac = quot[15:0];
      end
      expected_durations.push_back(r);
      done = 1'b1;
      stage = PH_DONE;
    endfunction

    function void fail_search();
      if (stage == PH_SEEK_MOOV) post_result(ST_NO_MOOV, 1'b0);
      else post_result(ST_NO_MVHD, 1'b0);
    endfunction

    function void header_done(logic [63:0] hlen);
      logic [31:0] target;
      target = (stage == PH_SEEK_MOOV) ? TAG_MOOV : TAG_MVHD;
      pos = '0;
      if (tag_acc == target) begin
        if (stage == PH_SEEK_MOOV) begin
          stage = PH_SEEK_MVHD;
        end else begin
          stage = PH_BODY;
          ver = '0;
          scale = '0;
          ticks = '0;
        end
      end else if (size_acc == 0 || size_acc < hlen) begin
        fail_search();
      end else begin
        skip_cnt = size_acc - hlen;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned c, tlen, dlen, ts_at, du_at;
      c = 32'(pos);
      if (stage == PH_BODY) begin
        tlen = (ver == 8'd1) ? 16 : 8;
        dlen = (ver == 8'd1) ? 8 : 4;
        ts_at = 4 + tlen;
        du_at = ts_at + 4;
        if (c == 0) ver = b;
        else if (c >= ts_at && c < du_at) scale = {scale[23:0], b};
        else if (c >= du_at && c < du_at + dlen) ticks = {ticks[55:0], b};
        pos = 6'(c + 1);
        if (c != 0 && c + 1 == du_at + dlen) begin
          if (scale == 0) post_result(ST_TS_ZERO, 1'b1);
          else post_result(ST_FOUND, 1'b1);
        end
      end else if (stage != PH_DONE) begin
        if (skip_cnt != 0) begin
          skip_cnt = skip_cnt - 1;
        end else begin
          if (c == 0 || c == 8) size_acc = {56'd0, b};
          else if (c < 4 || (c > 8 && c < 16)) size_acc = {size_acc[55:0], b};
          else tag_acc = {tag_acc[23:0], b};
          pos = 6'(c + 1);
          if (c == 7 && size_acc != 1) header_done(HDR_LEN);
          else if (c >= 15) header_done(LARGE_HDR_LEN);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      if (!done) take_byte(b);
      if (fin) begin
        if (!done) fail_search();
        restart();
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(duration_rec_t got);
      duration_rec_t want;
      if (expected_durations.size() == 0) begin
        $error("result beat with nothing expected, status %0d", got.status);
        errors++;
      end else begin
        want = expected_durations.pop_front();
        compare("status", 64'(want.status), 64'(got.status));
        compare("header_version", 64'(want.version), 64'(got.version));
        compare("ticks_per_second", 64'(want.scale), 64'(got.scale));
        compare("duration_ticks", want.ticks, got.ticks);
        compare("whole_seconds", want.whole, got.whole);
        compare("second_fraction", 64'(want.frac), 64'(got.frac));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [7:0]  header_version_o;
  logic [31:0] ticks_per_second_o;
  logic [63:0] duration_ticks_o;
  logic [63:0] whole_seconds_o;
  logic [15:0] second_fraction_o;

  duration_scoreboard sb = new();
  logic [7:0] file_bytes[$];
  int  bytes_sent = 0;
  int  files_done = 0;
  int  out_beats = 0;
  int  idle_cycles = 0;
  bit  tx_quiet = 1'b0;

  mp4_movie_duration_parser DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .header_version_o   (header_version_o),
    .ticks_per_second_o (ticks_per_second_o),
    .duration_ticks_o   (duration_ticks_o),
    .whole_seconds_o    (whole_seconds_o),
    .second_fraction_o  (second_fraction_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // file building, big-endian
  function void put_bytes(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function void put_filler(int n);
    repeat (n) file_bytes.push_back(8'($urandom()));
  endfunction

  function void trim(int n);
    repeat (n) file_bytes.delete(file_bytes.size() - 1);
  endfunction

  function logic [31:0] other_tag();
    logic [31:0] t;
    t = $urandom();
    if (t == TAG_MOOV || t == TAG_MVHD) t = t ^ 32'd1;
    return t;
  endfunction

  function void put_header(logic [63:0] size, logic [31:0] tag, bit long_hdr);
    if (long_hdr) begin
      put_bytes(64'd1, 4);
      put_bytes(64'(tag), 4);
      put_bytes(size, 8);
    end else begin
      put_bytes(size, 4);
      put_bytes(64'(tag), 4);
    end
  endfunction

  function void skip_box(bit long_hdr);
    int n;
    n = $urandom_range(0, 5);
    put_header(64'((long_hdr ? 16 : 8) + n), other_tag(), long_hdr);
    put_filler(n);
  endfunction

  function void wanted_header(logic [31:0] tag);
    bit long_hdr;
    logic [63:0] size;
    long_hdr = ($urandom_range(0, 5) == 0);
    size = long_hdr ? {$urandom(), $urandom()} : {32'd0, $urandom()};
    if (!long_hdr && size == 1) size = 0;
    put_header(size, tag, long_hdr);
  endfunction

  function void mvhd_body(logic [7:0] v, logic [31:0] ts, logic [63:0] dur);
    put_bytes(64'(v), 1);
    put_filler(3);
    put_filler(v == 8'd1 ? 16 : 8);
    put_bytes(64'(ts), 4);
    put_bytes(dur, v == 8'd1 ? 8 : 4);
  endfunction

  function void build_good_file();
    int r;
    logic [7:0] v;
    logic [31:0] ts;
    logic [63:0] dur;
    repeat ($urandom_range(0, 2)) skip_box($urandom_range(0, 5) == 0);
    wanted_header(TAG_MOOV);
    repeat ($urandom_range(0, 2)) skip_box($urandom_range(0, 5) == 0);
    wanted_header(TAG_MVHD);
    r = $urandom_range(0, 9);
    v = (r < 4) ? 8'd0 : (r < 8) ? 8'd1 : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r == 0) ts = 32'd0;
    else if (r < 4) ts = $urandom_range(1, 1000);
    else if (r == 4) ts = 32'hFFFF_FFFF;
    else ts = $urandom();
    r = $urandom_range(0, 3);
    if (r == 0) dur = 64'($urandom_range(0, 5000));
    else if (r == 1) dur = {32'd0, $urandom()};
    else dur = {$urandom(), $urandom()};
    mvhd_body(v, ts, dur);
    put_filler($urandom_range(0, 3));
  endfunction

  function void build_random_file();
    int kind;
    int sz;
    kind = $urandom_range(0, 99);
    file_bytes.delete();
    if (kind < 80) begin
      build_good_file();
    end else if (kind < 86) begin
      build_good_file();
      trim($urandom_range(0, file_bytes.size() - 1));
    end else if (kind < 91) begin
      put_filler($urandom_range(1, 30));
    end else if (kind < 96) begin
      if ($urandom_range(0, 1)) wanted_header(TAG_MOOV);
      repeat ($urandom_range(0, 1)) skip_box($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        put_header(64'($urandom_range(0, 15)), other_tag(), 1'b1);
      end else begin
        sz = $urandom_range(0, 7);
        if (sz == 1) sz = 0;
        put_header(64'(sz), other_tag(), 1'b0);
      end
      put_filler($urandom_range(0, 8));
    end else begin
      repeat ($urandom_range(1, 3)) skip_box($urandom_range(0, 3) == 0);
    end
  endfunction

  function void build_directed(int k);
    file_bytes.delete();
    case (k)
      0: begin
        put_header(108, TAG_MOOV, 1'b0);
        put_header(108, TAG_MVHD, 1'b0);
        mvhd_body(8'd0, 32'd1000, 64'd12345);
      end
      1: begin
        put_header(200, TAG_MOOV, 1'b1);
        put_header(120, TAG_MVHD, 1'b0);
        mvhd_body(8'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      2: begin
        put_header(100, TAG_MOOV, 1'b0);
        put_header(100, TAG_MVHD, 1'b0);
        mvhd_body(8'd0, 32'd0, 64'd5);
      end
      3: begin
        put_header(100, TAG_MOOV, 1'b0);
        put_header(100, TAG_MVHD, 1'b0);
        mvhd_body(8'hFF, 32'd1, 64'hFFFF_FFFF);
      end
      4: begin
        skip_box(1'b0);
        skip_box(1'b1);
      end
      5: begin
        put_header(0, other_tag(), 1'b0);
        put_filler(6);
      end
      6: begin
        put_header(100, TAG_MOOV, 1'b0);
        put_header(5, other_tag(), 1'b0);
        put_filler(3);
      end
      7: begin
        put_header(20, other_tag(), 1'b1);
        put_filler(4);
        put_header(100, TAG_MOOV, 1'b0);
        put_header(100, TAG_MVHD, 1'b0);
        mvhd_body(8'd1, 32'd90000, 64'h0000_0012_3456_789A);
      end
      8: begin
        put_header(12, other_tag(), 1'b1);
        put_filler(2);
      end
      9: begin
        put_header(100, TAG_MOOV, 1'b0);
        put_header(100, TAG_MVHD, 1'b0);
        mvhd_body(8'd0, 32'd600, 64'd7777);
        trim(7);
      end
      10: put_bytes(64'hFF, 1);
      11: put_bytes(64'h00, 1);
      12: begin
        put_header(100, TAG_MOOV, 1'b0);
        put_header(100, TAG_MVHD, 1'b0);
        mvhd_body(8'd0, 32'd48000, 64'd96001);
        put_bytes(64'hFFFF_FFFF, 4);
      end
      13: begin
        put_header(40, TAG_MVHD, 1'b0);
        put_filler(32);
        put_header(100, TAG_MOOV, 1'b0);
        put_header(100, TAG_MVHD, 1'b0);
        mvhd_body(8'd1, 32'd3, 64'd10);
      end
      default: put_header(100, TAG_MOOV, 1'b0);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    tx_quiet = ($urandom_range(0, 3) == 0);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_done++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_durations.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'd0;
    last_byte_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int k = 0; k < DIRECTED_FILES; k++) begin
      build_directed(k);
      send_file();
    end
    wait_drain();
    while (bytes_sent < BYTE_TARGET || files_done < FILE_TARGET) begin
      if (files_done == DRAIN_AT_FILE) wait_drain();
      build_random_file();
      send_file();
    end
    wait_drain();
    repeat (100) @(posedge clk_i);
    if (sb.expected_durations.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_durations.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("mp4_movie_duration_parser: match");
    end else begin
      $display("mp4_movie_duration_parser: mismatch");
    end
    $finish;
  end

  // receiver: random stall per beat, one long hold-off
  initial begin : receiver
    int wait_cnt;
    int seen_beats;
    bit rx_quiet;
    bit held;
    out_stall_i = 1'b0;
    wait_cnt = $urandom_range(0, 6);
    seen_beats = 0;
    rx_quiet = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_beats != seen_beats) begin
        seen_beats = out_beats;
        if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
        wait_cnt = rx_quiet ? 0 : $urandom_range(0, 6);
        if (!held && seen_beats == LONG_HOLD_AT) begin
          held = 1'b1;
          wait_cnt = LONG_HOLD;
        end
      end
      out_stall_i <= (wait_cnt != 0);
      if (wait_cnt != 0) wait_cnt--;
    end
  end

  always @(posedge clk_i) begin : monitor
    duration_rec_t seen;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(data_byte_i, last_byte_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        seen.status = status_e'(status_o);
        seen.version = header_version_o;
        seen.scale = ticks_per_second_o;
        seen.ticks = duration_ticks_o;
        seen.whole = whole_seconds_o;
        seen.frac = second_fraction_o;
        sb.check_result(seen);
        out_beats++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("mp4_movie_duration_parser: mismatch");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/mmdp_pkg.sv
hdl/mmdp_front.sv
hdl/mmdp_fifo.sv
hdl/mmdp_divider.sv
hdl/mp4_movie_duration_parser.sv
tb/tb_mp4_movie_duration_parser.sv
